// File: hw/rtl/mtfl_pkg.sv
// Shared constants for the move-to-front recent list.
package mtfl_pkg;

  // Width of one item id.
  localparam int unsigned ID_W = 16;

  // Default number of slots in the list, front slot included.
  localparam int unsigned LIST_DEPTH_DEF = 8;

endpackage : mtfl_pkg

// File: hw/rtl/mtfl_cell.sv
// One slot of the recent list after the front, with its match and shift logic.
module mtfl_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift_en,
  input  logic [mtfl_pkg::ID_W-1:0] id,
  input  logic [mtfl_pkg::ID_W-1:0] carry_in,
  input  logic                      stop_in,
  output logic [mtfl_pkg::ID_W-1:0] slot_q,
  output logic                      stop_out
);

  logic [mtfl_pkg::ID_W-1:0] slot_r;
  logic [mtfl_pkg::ID_W-1:0] slot_nxt;
  logic                      hit;

  // This slot ends the shift when it holds the same id or is empty.
  assign hit      = (slot_r == id) || (slot_r == '0);
  assign stop_out = stop_in | hit;

  // The slot takes its neighbor's old entry unless an earlier slot ended the shift.
  always_comb begin
    slot_nxt = slot_r;
    if (shift_en && !stop_in) begin
      slot_nxt = carry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_q = slot_r;

endmodule : mtfl_cell

// File: hw/rtl/move_to_front_recent_list.sv
// Top level of the move-to-front recent list: front slot, cell chain and result register.
//
//   Channel   Direction  Handshake          Payload
//   input     in         start, busy        in_item_id
//   result    out        out_valid strobe   out_already_current, out_evicted_valid,
//                                           out_evicted_id
//
// The whole cell chain compares and shifts in the cycle of acceptance, so a new id is
// taken on every clock and busy stays low.
// The result appears on the out_ ports in the cycle after acceptance, flagged by out_valid for one cycle.
// The longest path is the one-bit stop chain that ripples through all LIST_DEPTH-1 cells.
// Synchronous reset empties the list (all slots zero); no clearing pass is needed.
// The receiver cannot stall, so nothing is ever held back.
module move_to_front_recent_list #(
  parameter int unsigned LIST_DEPTH = mtfl_pkg::LIST_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [mtfl_pkg::ID_W-1:0] in_item_id,
  output logic                      out_valid,
  output logic                      out_already_current,
  output logic                      out_evicted_valid,
  output logic [mtfl_pkg::ID_W-1:0] out_evicted_id
);

  logic                      accept;
  logic                      front_hit;
  logic                      shift_en;
  logic [mtfl_pkg::ID_W-1:0] front_r;
  logic [mtfl_pkg::ID_W-1:0] front_nxt;
  logic [mtfl_pkg::ID_W-1:0] slot_q [LIST_DEPTH];
  logic                      stop_c [LIST_DEPTH];
  logic                      evict;

  logic                      out_valid_r;
  logic                      already_r;
  logic                      evicted_valid_r;
  logic [mtfl_pkg::ID_W-1:0] evicted_id_r;

  // The chain finishes a transaction in the cycle of acceptance, so the block is never busy.
  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign front_hit = (front_r == in_item_id);
  assign shift_en  = accept && !front_hit;

  // The front slot takes the new id whenever an accepted id differs from the current front.
  always_comb begin
    front_nxt = front_r;
    if (shift_en) begin
      front_nxt = in_item_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
    end else begin
      front_r <= front_nxt;
    end
  end

  assign slot_q[0] = front_r;
  assign stop_c[0] = 1'b0;

  // Row of cells behind the front; each hands its old entry and stop flag to the next.
  for (genvar i = 1; i < LIST_DEPTH; i++) begin : g_cell
    if (i < LIST_DEPTH - 1) begin : g_mid
      mtfl_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .id       (in_item_id),
        .carry_in (slot_q[i-1]),
        .stop_in  (stop_c[i-1]),
        .slot_q   (slot_q[i]),
        .stop_out (stop_c[i])
      );
    end else begin : g_last
      mtfl_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .id       (in_item_id),
        .carry_in (slot_q[i-1]),
        .stop_in  (stop_c[i-1]),
        .slot_q   (slot_q[i]),
        .stop_out (stop_c[i])
      );
    end
  end

  // The last entry drops off when no slot after the front ended the shift.
  assign evict = shift_en && !stop_c[LIST_DEPTH-1];

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  // Result payload, captured with the transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      already_r       <= front_hit;
      evicted_valid_r <= evict;
      evicted_id_r    <= evict ? slot_q[LIST_DEPTH-1] : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_already_current = already_r;
  assign out_evicted_valid   = evicted_valid_r;
  assign out_evicted_id      = evicted_id_r;

endmodule : move_to_front_recent_list
